FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, idle during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/mabsg_pkg.sv
package mabsg_pkg;

  localparam int MAX_AXES = 8;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_BEGIN = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_STEP_INV = 2'd0,
    CFG_DIR_INV  = 2'd1,
    CFG_SYNC     = 2'd2
  } cfg_idx_t;

  localparam int FLAG_SKIP   = 0;
  localparam int FLAG_CRUISE = 1;

  localparam int HDR_EVENT = 0;
  localparam int HDR_DIR   = 1;
  localparam int HDR_LINE  = 2;
  localparam int HDR_SEQ   = 3;
  localparam int HDR_WORDS = 4;

  typedef struct packed {
    logic        upd;
    logic        load;
    logic        skip;
    logic [31:0] event_count;
  } lane_ctrl_t;

endpackage

FILE: sv/mabsg_axis.sv
module mabsg_axis (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mabsg_pkg::lane_ctrl_t  ctrl,
  input  logic                   dir,
  input  logic [31:0]            pending_steps,
  output logic                   step,
  output logic signed [31:0]     position_nxt
);

  logic [31:0]        steps_r, steps_nxt;
  logic [31:0]        counter_r, counter_nxt;
  logic signed [31:0] position_r;
  logic [31:0]        steps_eff;
  logic [31:0]        base;
  logic [31:0]        sum;
  logic               hit;

  always_comb begin
    steps_eff = ctrl.load ? pending_steps : steps_r;
    base      = ctrl.load ? ctrl.event_count : counter_r;
    sum       = base + steps_eff;
    hit       = sum > ctrl.event_count;
    step      = ctrl.upd && hit;

    steps_nxt    = steps_r;
    counter_nxt  = counter_r;
    position_nxt = position_r;
    if (ctrl.upd) begin
      if (ctrl.load) begin
        steps_nxt = pending_steps;
      end
      counter_nxt = hit ? (sum - ctrl.event_count) : sum;
      if (hit && !ctrl.skip) begin
        position_nxt = dir ? (position_r - 32'sd1) : (position_r + 32'sd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r    <= '0;
      counter_r  <= '0;
      position_r <= '0;
    end else begin
      steps_r    <= steps_nxt;
      counter_r  <= counter_nxt;
      position_r <= position_nxt;
    end
  end

endmodule

FILE: sv/multi_axis_bresenham_step_generator_core.sv
// Bresenham step generator for up to AXES stepper axes. Every transaction on the input
// channel is one command: load a pending block word, a step tick, or begin motion, and it
// yields exactly one result transaction in the cycle after it is accepted. One transaction is
// accepted per clock cycle; in_ready drops only while the output register holds a result
// that out_ready does not take. The per-axis lanes add, compare and subtract their
// counters combinationally in the accepting cycle. Configuration writes are accepted
// at any time (cfg_ready is always high) and belong to idle periods.
module multi_axis_bresenham_step_generator_core #(
  parameter int AXES = 6
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_word_index,
  input  logic [31:0]        in_word_value,
  input  logic               in_seg_available,
  input  logic               in_new_block,
  input  logic [15:0]        in_segment_steps,
  input  logic [15:0]        in_timer_delay,
  input  logic [1:0]         in_segment_flags,
  input  logic [15:0]        in_spindle_delay,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_step_levels,
  output logic [7:0]         out_dir_bits,
  output logic               out_dir_update,
  output logic [15:0]        out_timer_period,
  output logic               out_timer_update,
  output logic               out_segment_done,
  output logic               out_running,
  output logic [31:0]        out_line_number,
  output logic [31:0]        out_seq_number,
  output logic [31:0]        out_last_sequence,
  output logic signed [31:0] out_axis_position
);

  localparam logic [4:0] AXES_W = 5'(AXES);

  // Configuration registers.
  logic [7:0] step_inv_r;
  logic [7:0] dir_inv_r;
  logic       sync_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_inv_r <= '0;
      dir_inv_r  <= '0;
      sync_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (mabsg_pkg::cfg_idx_t'(cfg_index))
        mabsg_pkg::CFG_STEP_INV: step_inv_r <= cfg_data;
        mabsg_pkg::CFG_DIR_INV:  dir_inv_r  <= cfg_data;
        mabsg_pkg::CFG_SYNC:     sync_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic acc;
  logic out_valid_r;
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  // Pending block store, written by load commands; each entry is read at a fixed place.
  logic [31:0] pend_steps_r [AXES];
  logic [31:0] hdr_r [mabsg_pkg::HDR_WORDS];
  logic        is_load;

  assign is_load = acc && (mabsg_pkg::cmd_t'(in_cmd) == mabsg_pkg::CMD_LOAD);

  always_ff @(posedge clk) begin
    if (is_load) begin
      for (int i = 0; i < AXES; i++) begin
        if (in_word_index == 4'(i)) begin
          pend_steps_r[i] <= in_word_value;
        end
      end
      for (int k = 0; k < mabsg_pkg::HDR_WORDS; k++) begin
        if (in_word_index == 4'(AXES + k)) begin
          hdr_r[k] <= in_word_value;
        end
      end
    end
  end

  // Control state.
  logic [31:0] evt_r, evt_nxt;
  logic [7:0]  adir_r, adir_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic        seg_run_r, seg_run_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [7:0]  step_r, step_nxt;
  logic [7:0]  dir_r, dir_nxt;
  logic        dir_wr_r, dir_wr_nxt;
  logic        motion_r, motion_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] last_r, last_nxt;

  logic        tick_act, take, load_blk, shut, upd;
  logic [1:0]  flags_eff;
  logic [7:0]  adir_eff;
  logic [15:0] ticks_eff;
  logic [31:0] evt_eff;

  logic [7:0]  o_step;
  logic        o_dirupd;
  logic [15:0] o_period;
  logic        o_tupd;
  logic        o_done;

  logic [AXES-1:0]                lane_step;
  logic [mabsg_pkg::MAX_AXES-1:0] bits8;
  logic signed [31:0]             lane_pos [AXES];
  logic signed [31:0]             pos_sel;
  mabsg_pkg::lane_ctrl_t          lane_ctrl;

  assign tick_act  = acc && (mabsg_pkg::cmd_t'(in_cmd) == mabsg_pkg::CMD_TICK) && motion_r;
  assign take      = tick_act && !seg_run_r && in_seg_available;
  assign load_blk  = take && in_new_block;
  assign shut      = tick_act && !seg_run_r && !in_seg_available;
  assign upd       = tick_act && !shut;
  assign flags_eff = take ? in_segment_flags : flags_r;
  assign adir_eff  = load_blk ? hdr_r[mabsg_pkg::HDR_DIR][7:0] : adir_r;
  assign ticks_eff = take ? in_segment_steps : ticks_r;
  assign evt_eff   = load_blk ? hdr_r[mabsg_pkg::HDR_EVENT] : evt_r;

  assign lane_ctrl.upd         = upd;
  assign lane_ctrl.load        = load_blk;
  assign lane_ctrl.skip        = flags_eff[mabsg_pkg::FLAG_SKIP];
  assign lane_ctrl.event_count = evt_eff;

  for (genvar g = 0; g < AXES; g++) begin : g_axis
    mabsg_axis u_axis (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (lane_ctrl),
      .dir           (adir_eff[g]),
      .pending_steps (pend_steps_r[g]),
      .step          (lane_step[g]),
      .position_nxt  (lane_pos[g])
    );
  end

  assign bits8 = mabsg_pkg::MAX_AXES'(lane_step);

  always_comb begin
    pos_sel = '0;
    for (int i = 0; i < AXES; i++) begin
      if (in_word_index == 4'(i)) begin
        pos_sel = lane_pos[i];
      end
    end
  end

  always_comb begin
    evt_nxt     = evt_r;
    adir_nxt    = adir_r;
    ticks_nxt   = ticks_r;
    seg_run_nxt = seg_run_r;
    flags_nxt   = flags_r;
    step_nxt    = step_r;
    dir_nxt     = dir_r;
    dir_wr_nxt  = dir_wr_r;
    motion_nxt  = motion_r;
    line_nxt    = line_r;
    seq_nxt     = seq_r;
    last_nxt    = last_r;
    o_step      = '0;
    o_dirupd    = 1'b0;
    o_period    = '0;
    o_tupd      = 1'b0;
    o_done      = 1'b0;

    if (acc) begin
      case (mabsg_pkg::cmd_t'(in_cmd))
        mabsg_pkg::CMD_BEGIN: begin
          if (!motion_r) begin
            motion_nxt = 1'b1;
            step_nxt   = step_inv_r;
          end
        end
        mabsg_pkg::CMD_TICK: begin
          if (motion_r) begin
            if (!dir_wr_r) begin
              o_dirupd   = 1'b1;
              dir_wr_nxt = 1'b1;
            end
            o_step = step_r;
            if (take) begin
              o_period    = in_timer_delay;
              o_tupd      = 1'b1;
              flags_nxt   = in_segment_flags;
              seg_run_nxt = 1'b1;
              if (load_blk) begin
                dir_wr_nxt = 1'b0;
                line_nxt   = hdr_r[mabsg_pkg::HDR_LINE];
                last_nxt   = seq_r;
                seq_nxt    = hdr_r[mabsg_pkg::HDR_SEQ];
                evt_nxt    = hdr_r[mabsg_pkg::HDR_EVENT];
                adir_nxt   = hdr_r[mabsg_pkg::HDR_DIR][7:0];
              end
              dir_nxt = adir_eff ^ dir_inv_r;
            end
            if (shut) begin
              motion_nxt = 1'b0;
              last_nxt   = seq_r;
              seq_nxt    = '0;
              dir_wr_nxt = 1'b0;
              step_nxt   = '0;
            end else begin
              ticks_nxt = ticks_eff - 16'd1;
              if (sync_r && flags_eff[mabsg_pkg::FLAG_CRUISE] &&
                  (in_spindle_delay != 16'd0)) begin
                o_period = in_spindle_delay;
                o_tupd   = 1'b1;
              end
              if (ticks_nxt == 16'd0) begin
                seg_run_nxt = 1'b0;
                o_done      = 1'b1;
              end
              step_nxt = bits8 ^ step_inv_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_r     <= '0;
      adir_r    <= '0;
      ticks_r   <= '0;
      seg_run_r <= 1'b0;
      flags_r   <= '0;
      step_r    <= '0;
      dir_r     <= '0;
      dir_wr_r  <= 1'b0;
      motion_r  <= 1'b0;
      line_r    <= '0;
      seq_r     <= '0;
      last_r    <= '0;
    end else begin
      evt_r     <= evt_nxt;
      adir_r    <= adir_nxt;
      ticks_r   <= ticks_nxt;
      seg_run_r <= seg_run_nxt;
      flags_r   <= flags_nxt;
      step_r    <= step_nxt;
      dir_r     <= dir_nxt;
      dir_wr_r  <= dir_wr_nxt;
      motion_r  <= motion_nxt;
      line_r    <= line_nxt;
      seq_r     <= seq_nxt;
      last_r    <= last_nxt;
    end
  end

  // Result register.
  logic [7:0]         res_step_r;
  logic [7:0]         res_dir_r;
  logic               res_dirupd_r;
  logic [15:0]        res_period_r;
  logic               res_tupd_r;
  logic               res_done_r;
  logic               res_run_r;
  logic [31:0]        res_line_r;
  logic [31:0]        res_seq_r;
  logic [31:0]        res_last_r;
  logic signed [31:0] res_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_step_r   <= o_step;
      res_dir_r    <= dir_nxt;
      res_dirupd_r <= o_dirupd;
      res_period_r <= o_period;
      res_tupd_r   <= o_tupd;
      res_done_r   <= o_done;
      res_run_r    <= motion_nxt;
      res_line_r   <= line_nxt;
      res_seq_r    <= seq_nxt;
      res_last_r   <= last_nxt;
      res_pos_r    <= ({1'b0, in_word_index} < AXES_W) ? pos_sel : 32'sd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_step_levels   = res_step_r;
  assign out_dir_bits      = res_dir_r;
  assign out_dir_update    = res_dirupd_r;
  assign out_timer_period  = res_period_r;
  assign out_timer_update  = res_tupd_r;
  assign out_segment_done  = res_done_r;
  assign out_running       = res_run_r;
  assign out_line_number   = res_line_r;
  assign out_seq_number    = res_seq_r;
  assign out_last_sequence = res_last_r;
  assign out_axis_position = res_pos_r;

endmodule

FILE: sv/mabsg_checker.sv
`include "assert_macros.svh"

module mabsg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_step_levels,
  input logic [15:0]        out_timer_period,
  input logic               out_timer_update,
  input logic               out_segment_done,
  input logic               out_running,
  input logic [31:0]        out_seq_number,
  input logic signed [31:0] out_axis_position
);

  logic [71:0] out_payload;
  assign out_payload = {out_step_levels, out_seq_number, out_axis_position};

  // A stalled result transaction keeps its payload.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // The input side is never held off while the output register can drain.
  `ASSERT_IMPLIES(a_in_ready, !out_valid || out_ready, in_ready)

  // An idle block reports no running sequence.
  `ASSERT_IMPLIES(a_idle_seq, out_valid && !out_running, out_seq_number == 32'd0)

  // A timer value is shown only together with its update strobe.
  `ASSERT_IMPLIES(a_period, out_valid && !out_timer_update, out_timer_period == 16'd0)

  // A segment can only finish while motion stays active.
  `ASSERT_IMPLIES(a_done_run, out_valid && out_segment_done, out_running)

endmodule

bind multi_axis_bresenham_step_generator_core mabsg_checker u_mabsg_checker (.*);
